// ----- src/spr_pkg.sv -----
package spr_pkg;

    // Timer clock of the pulse generator, in Hz.
    localparam int TIMER_HZ = 1000000;

    localparam int CNT_W  = 16;
    localparam int POS_W  = 32;
    localparam int ERR_W  = POS_W + 1;
    localparam int TOL_W  = 16;
    localparam int RATE_W = 15;
    localparam int ACC_W  = 12;
    localparam int GAIN_W = 8;
    localparam int PER_W  = 20;
    localparam int CMP_W  = 19;

    localparam logic [PER_W-1:0] PERIOD_MAX  = {PER_W{1'b1}};
    localparam logic [CMP_W-1:0] COMPARE_MAX = {CMP_W{1'b1}};

    // Shared divider: wide enough for |error| * gain_num and for TIMER_HZ.
    localparam int TIMER_W  = $clog2(TIMER_HZ + 1);
    localparam int DIV_DW   = ERR_W + GAIN_W;
    localparam int DIV_SW   = RATE_W;
    localparam int DIV_CW   = $clog2(DIV_DW + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_NUM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DEN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_INV   = 3'd7;

    localparam logic [POS_W-1:0]  TARGET_RST    = 32'd4000;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST = 16'd2;
    localparam logic [RATE_W-1:0] MAX_RATE_RST  = 15'd3000;
    localparam logic [RATE_W-1:0] MIN_RATE_RST  = 15'd150;
    localparam logic [ACC_W-1:0]  ACCEL_RST     = 12'd80;
    localparam logic [GAIN_W-1:0] GAIN_NUM_RST  = 8'd1;
    localparam logic [GAIN_W-1:0] GAIN_DEN_RST  = 8'd3;

    // Result beat layout.
    localparam int OUT_POS_LSB  = 0;
    localparam int OUT_RATE_LSB = OUT_POS_LSB + POS_W;
    localparam int OUT_DIR_BIT  = OUT_RATE_LSB + RATE_W;
    localparam int OUT_PEN_BIT  = OUT_DIR_BIT + 1;
    localparam int OUT_PER_LSB  = OUT_PEN_BIT + 1;
    localparam int OUT_CMP_LSB  = OUT_PER_LSB + PER_W;
    localparam int OUT_ARR_BIT  = OUT_CMP_LSB + CMP_W;
    localparam int OUT_USED_W   = OUT_ARR_BIT + 1;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;
    localparam int IN_DATA_W    = 16;

    // Microcode.
    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT = 4'd1;
    localparam logic [OP_W-1:0] OP_TRACK  = 4'd2;
    localparam logic [OP_W-1:0] OP_ERR    = 4'd3;
    localparam logic [OP_W-1:0] OP_ABS    = 4'd4;
    localparam logic [OP_W-1:0] OP_TOL    = 4'd5;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd6;
    localparam logic [OP_W-1:0] OP_CLAMP  = 4'd7;
    localparam logic [OP_W-1:0] OP_SLEW   = 4'd8;
    localparam logic [OP_W-1:0] OP_PERIOD = 4'd9;
    localparam logic [OP_W-1:0] OP_PCALC  = 4'd10;
    localparam logic [OP_W-1:0] OP_OUT    = 4'd11;

    localparam logic [COND_W-1:0] C_NEXT        = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
    localparam logic [COND_W-1:0] C_NO_INPUT    = 4'd2;
    localparam logic [COND_W-1:0] C_REZERO      = 4'd3;
    localparam logic [COND_W-1:0] C_ARRIVED     = 4'd4;
    localparam logic [COND_W-1:0] C_IN_TOL      = 4'd5;
    localparam logic [COND_W-1:0] C_DIV_MORE    = 4'd6;
    localparam logic [COND_W-1:0] C_RATE_ZERO   = 4'd7;
    localparam logic [COND_W-1:0] C_OUT_BLOCKED = 4'd8;

    localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] S_TRACK  = 4'd1;
    localparam logic [STEP_W-1:0] S_CHECK  = 4'd2;
    localparam logic [STEP_W-1:0] S_ERR    = 4'd3;
    localparam logic [STEP_W-1:0] S_ABS    = 4'd4;
    localparam logic [STEP_W-1:0] S_TOL    = 4'd5;
    localparam logic [STEP_W-1:0] S_GDIV   = 4'd6;
    localparam logic [STEP_W-1:0] S_CLAMP  = 4'd7;
    localparam logic [STEP_W-1:0] S_SLEW   = 4'd8;
    localparam logic [STEP_W-1:0] S_PERIOD = 4'd9;
    localparam logic [STEP_W-1:0] S_TDIV   = 4'd10;
    localparam logic [STEP_W-1:0] S_PCALC  = 4'd11;
    localparam logic [STEP_W-1:0] S_OUT    = 4'd12;
    localparam logic [STEP_W-1:0] S_FIN    = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } uop_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [DIV_CW-1:0] count;
    } div_ctl_t;

    // Control store: a taken condition jumps to target, otherwise the
    // sequencer moves to the following step.
    function automatic uop_t uop_rom(input logic [STEP_W-1:0] pc);
        uop_t u;
        case (pc)
            S_IDLE:   u = '{OP_ACCEPT, C_NO_INPUT,    S_IDLE};
            S_TRACK:  u = '{OP_TRACK,  C_REZERO,      S_PERIOD};
            S_CHECK:  u = '{OP_NOP,    C_ARRIVED,     S_PERIOD};
            S_ERR:    u = '{OP_ERR,    C_NEXT,        S_IDLE};
            S_ABS:    u = '{OP_ABS,    C_NEXT,        S_IDLE};
            S_TOL:    u = '{OP_TOL,    C_IN_TOL,      S_PERIOD};
            S_GDIV:   u = '{OP_DIV,    C_DIV_MORE,    S_GDIV};
            S_CLAMP:  u = '{OP_CLAMP,  C_NEXT,        S_IDLE};
            S_SLEW:   u = '{OP_SLEW,   C_NEXT,        S_IDLE};
            S_PERIOD: u = '{OP_PERIOD, C_RATE_ZERO,   S_OUT};
            S_TDIV:   u = '{OP_DIV,    C_DIV_MORE,    S_TDIV};
            S_PCALC:  u = '{OP_PCALC,  C_NEXT,        S_IDLE};
            S_OUT:    u = '{OP_OUT,    C_OUT_BLOCKED, S_OUT};
            S_FIN:    u = '{OP_NOP,    C_ALWAYS,      S_IDLE};
            default:  u = '{OP_NOP,    C_ALWAYS,      S_IDLE};
        endcase
        return u;
    endfunction

    // Move cur toward goal by at most accel.
    function automatic logic [RATE_W-1:0] slew(input logic [RATE_W-1:0] cur,
                                               input logic [RATE_W-1:0] goal,
                                               input logic [ACC_W-1:0]  accel);
        logic [RATE_W:0]   up;
        logic [RATE_W-1:0] dn;
        up = {1'b0, cur} + {{(RATE_W + 1 - ACC_W){1'b0}}, accel};
        dn = (cur > RATE_W'(accel)) ? cur - RATE_W'(accel) : '0;
        if (cur < goal) begin
            return (up > {1'b0, goal}) ? goal : up[RATE_W-1:0];
        end else if (cur > goal) begin
            return (dn < goal) ? goal : dn;
        end
        return cur;
    endfunction

endpackage

// ----- src/spr_div.sv -----
module spr_div
    import spr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_ctl_t          ctl,
    input  logic [DIV_DW-1:0] dividend,
    input  logic [DIV_SW-1:0] divisor,
    output logic [DIV_DW-1:0] quotient,
    output logic              last
);

    logic [DIV_DW-1:0] dvd_reg, dvd_next;
    logic [DIV_DW-1:0] quo_reg, quo_next;
    logic [DIV_SW-1:0] dsr_reg, dsr_next;
    logic [DIV_SW-1:0] rem_reg, rem_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_SW:0]   trial;
    logic              fits;

    // Restoring division, one quotient bit per step, dividend MSB first.
    always_comb begin
        trial    = {rem_reg, dvd_reg[DIV_DW-1]};
        fits     = trial >= {1'b0, dsr_reg};
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (ctl.load) begin
            dvd_next = dividend;
            quo_next = '0;
            dsr_next = divisor;
            rem_next = '0;
            cnt_next = ctl.count;
        end else if (ctl.step) begin
            dvd_next = {dvd_reg[DIV_DW-2:0], 1'b0};
            quo_next = {quo_reg[DIV_DW-2:0], fits};
            rem_next = fits ? DIV_SW'(trial - {1'b0, dsr_reg}) : trial[DIV_SW-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == DIV_CW'(1));

endmodule

// ----- src/stepper_position_ramp_controller_core.sv -----
// A result beat follows its input beat. While moving, a tick makes two passes of the
// bit-serial divider (41 and 20 steps); ramping down inside the tolerance, it makes
// only the timer pass; on the stopping tick, after arrival and on rezero, neither.
// One tick is worked at a time: the next input beat is taken only after the result
// shows and the sequencer passes its final step; a stalled result delays the next one.
// Reset (aresetn low, synchronous) restores register defaults, clears control state.
module stepper_position_ramp_controller_core
    import spr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // encoder_count[15:0]
    input  logic [0:0]            s_tuser,   // rezero[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // position[31:0], rate[46:32], direction[47], pulse_enable[48],
    // period_ticks[68:49], compare_ticks[87:69], arrived[88], zero pad above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // Configuration.
    logic [POS_W-1:0]  target_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [RATE_W-1:0] max_rate_reg;
    logic [RATE_W-1:0] min_rate_reg;
    logic [ACC_W-1:0]  accel_reg;
    logic [GAIN_W-1:0] gain_num_reg;
    logic [GAIN_W-1:0] gain_den_reg;
    logic              dir_inv_reg;

    // Sequencer and datapath.
    logic [STEP_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0]  in_count_reg, in_count_next;
    logic              in_rz_reg, in_rz_next;
    logic [CNT_W-1:0]  last_count_reg, last_count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic              dir_reg, dir_next;
    logic              arrived_reg, arrived_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [ERR_W-1:0]  aerr_reg, aerr_next;
    logic              err_pos_reg, err_pos_next;
    logic [RATE_W-1:0] cmd_reg, cmd_next;
    logic [PER_W-1:0]  period_reg, period_next;
    logic [CMP_W-1:0]  compare_reg, compare_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    uop_t              uop;
    logic              taken;
    logic              in_tol;
    logic              out_blocked;
    logic [CNT_W-1:0]  delta;
    logic [RATE_W-1:0] rate_to_zero;
    logic [RATE_W-1:0] cmd_hi;
    logic [GAIN_W-1:0] den;
    logic [31:0]       q32;
    logic [31:0]       p32;
    logic [31:0]       c32;

    div_ctl_t          div_ctl;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_SW-1:0] div_divisor;
    logic [DIV_DW-1:0] div_quot;
    logic              div_last;

    spr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .last     (div_last)
    );

    assign uop         = uop_rom(pc_reg);
    assign s_tready    = aresetn && (uop.op == OP_ACCEPT);
    assign out_blocked = m_tvalid_reg && !m_tready;
    assign in_tol      = aerr_reg <= {{(ERR_W - TOL_W){1'b0}}, tol_reg};
    assign delta       = in_count_reg - last_count_reg;
    assign rate_to_zero = slew(rate_reg, '0, accel_reg);
    assign den         = (gain_den_reg == '0) ? GAIN_W'(1) : gain_den_reg;
    assign cmd_hi      = (div_quot > DIV_DW'(max_rate_reg)) ? max_rate_reg
                                                            : div_quot[RATE_W-1:0];
    assign q32         = 32'(div_quot[TIMER_W-1:0]);
    assign p32         = (q32 == '0) ? '0 : q32 - 32'd1;
    assign c32         = q32 >> 1;

    always_comb begin
        case (uop.cond)
            C_NEXT:        taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_NO_INPUT:    taken = !s_tvalid;
            C_REZERO:      taken = in_rz_reg;
            C_ARRIVED:     taken = arrived_reg;
            C_IN_TOL:      taken = in_tol;
            C_DIV_MORE:    taken = !div_last;
            C_RATE_ZERO:   taken = (rate_reg == '0);
            C_OUT_BLOCKED: taken = out_blocked;
            default:       taken = 1'b0;
        endcase
        pc_next = taken ? uop.target : pc_reg + 1'b1;
    end

    always_comb begin
        in_count_next   = in_count_reg;
        in_rz_next      = in_rz_reg;
        last_count_next = last_count_reg;
        pos_next        = pos_reg;
        rate_next       = rate_reg;
        dir_next        = dir_reg;
        arrived_next    = arrived_reg;
        err_next        = err_reg;
        aerr_next       = aerr_reg;
        err_pos_next    = err_pos_reg;
        cmd_next        = cmd_reg;
        period_next     = period_reg;
        compare_next    = compare_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        div_ctl         = '{load: 1'b0, step: 1'b0, count: '0};
        div_dividend    = '0;
        div_divisor     = '0;

        case (uop.op)
            OP_ACCEPT: begin
                if (s_tvalid) begin
                    in_count_next = s_tdata[CNT_W-1:0];
                    in_rz_next    = s_tuser[0];
                end
            end
            OP_TRACK: begin
                last_count_next = in_count_reg;
                if (in_rz_reg) begin
                    pos_next     = '0;
                    rate_next    = '0;
                    arrived_next = 1'b0;
                end else begin
                    pos_next = pos_reg + {{(POS_W - CNT_W){delta[CNT_W-1]}}, delta};
                end
            end
            OP_ERR: begin
                err_next = {target_reg[POS_W-1], target_reg} - {pos_reg[POS_W-1], pos_reg};
            end
            OP_ABS: begin
                aerr_next    = err_reg[ERR_W-1] ? -err_reg : err_reg;
                err_pos_next = !err_reg[ERR_W-1] && (err_reg != '0);
            end
            OP_TOL: begin
                if (in_tol) begin
                    rate_next    = rate_to_zero;
                    arrived_next = (rate_to_zero == '0);
                end else begin
                    dir_next     = err_pos_reg ^ dir_inv_reg;
                    div_ctl      = '{load: 1'b1, step: 1'b0, count: DIV_CW'(DIV_DW)};
                    div_dividend = DIV_DW'(aerr_reg) * DIV_DW'(gain_num_reg);
                    div_divisor  = DIV_SW'(den);
                end
            end
            OP_DIV: begin
                div_ctl = '{load: 1'b0, step: 1'b1, count: '0};
            end
            OP_CLAMP: begin
                // The lower clamp comes last, so it wins when min exceeds max.
                cmd_next = (cmd_hi < min_rate_reg) ? min_rate_reg : cmd_hi;
            end
            OP_SLEW: begin
                rate_next = slew(rate_reg, cmd_reg, accel_reg);
            end
            OP_PERIOD: begin
                period_next  = '0;
                compare_next = '0;
                div_ctl      = '{load: 1'b1, step: 1'b0, count: DIV_CW'(TIMER_W)};
                div_dividend = {TIMER_W'(TIMER_HZ), {(DIV_DW - TIMER_W){1'b0}}};
                div_divisor  = rate_reg;
            end
            OP_PCALC: begin
                period_next  = (p32 > 32'(PERIOD_MAX)) ? PERIOD_MAX : p32[PER_W-1:0];
                compare_next = (c32 > 32'(COMPARE_MAX)) ? COMPARE_MAX : c32[CMP_W-1:0];
            end
            OP_OUT: begin
                if (!out_blocked) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[OUT_POS_LSB +: POS_W]  = pos_reg;
                    m_tdata_next[OUT_RATE_LSB +: RATE_W] = rate_reg;
                    m_tdata_next[OUT_DIR_BIT]           = dir_reg;
                    m_tdata_next[OUT_PEN_BIT]           = (rate_reg != '0);
                    m_tdata_next[OUT_PER_LSB +: PER_W]  = period_reg;
                    m_tdata_next[OUT_CMP_LSB +: CMP_W]  = compare_reg;
                    m_tdata_next[OUT_ARR_BIT]           = arrived_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        in_count_reg <= in_count_next;
        in_rz_reg    <= in_rz_next;
        err_reg      <= err_next;
        aerr_reg     <= aerr_next;
        err_pos_reg  <= err_pos_next;
        cmd_reg      <= cmd_next;
        period_reg   <= period_next;
        compare_reg  <= compare_next;
        m_tdata_reg  <= m_tdata_next;
        if (!aresetn) begin
            pc_reg         <= S_IDLE;
            last_count_reg <= '0;
            pos_reg        <= '0;
            rate_reg       <= '0;
            dir_reg        <= 1'b0;
            arrived_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            pc_reg         <= pc_next;
            last_count_reg <= last_count_next;
            pos_reg        <= pos_next;
            rate_reg       <= rate_next;
            dir_reg        <= dir_next;
            arrived_reg    <= arrived_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TARGET_RST;
            tol_reg      <= TOLERANCE_RST;
            max_rate_reg <= MAX_RATE_RST;
            min_rate_reg <= MIN_RATE_RST;
            accel_reg    <= ACCEL_RST;
            gain_num_reg <= GAIN_NUM_RST;
            gain_den_reg <= GAIN_DEN_RST;
            dir_inv_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET:    target_reg   <= cfg_wdata[POS_W-1:0];
                REG_TOLERANCE: tol_reg      <= cfg_wdata[TOL_W-1:0];
                REG_MAX_RATE:  max_rate_reg <= cfg_wdata[RATE_W-1:0];
                REG_MIN_RATE:  min_rate_reg <= cfg_wdata[RATE_W-1:0];
                REG_ACCEL:     accel_reg    <= cfg_wdata[ACC_W-1:0];
                REG_GAIN_NUM:  gain_num_reg <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_DEN:  gain_den_reg <= cfg_wdata[GAIN_W-1:0];
                REG_DIR_INV:   dir_inv_reg  <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- src/spr_checker.sv -----
module spr_checker
    import spr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [RATE_W-1:0] rate;
    logic              pen;
    logic              arr;

    assign rate = m_tdata[OUT_RATE_LSB +: RATE_W];
    assign pen  = m_tdata[OUT_PEN_BIT];
    assign arr  = m_tdata[OUT_ARR_BIT];

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // One tick is worked at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a beat");

    a_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pen == (rate != '0)))
        else $error("pulse enable does not follow rate");

    a_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !pen |->
            (m_tdata[OUT_PER_LSB +: PER_W] == '0) && (m_tdata[OUT_CMP_LSB +: CMP_W] == '0))
        else $error("timer values nonzero while stopped");

    a_arrived: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && arr |-> (rate == '0))
        else $error("arrived with nonzero rate");

endmodule

bind stepper_position_ramp_controller_core spr_checker u_spr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
